// ----- rtl/ccb40_pkg.sv -----
// ---------------------------------------------------------------------------
// Callsign base-40 codec package
// Shared widths, payload types and character/digit conversion functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ccb40_pkg;

  localparam int unsigned WORD_W    = 48;
  localparam int unsigned NUM_POS   = 9;
  localparam int unsigned DIGIT_W   = 6;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned IN_CHAR_W = 8;
  localparam int unsigned BITS_W    = NUM_POS * DIGIT_W;
  localparam int unsigned NUM_CELLS = BITS_W;
  localparam int unsigned RADIX     = 40;

  localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

  localparam logic [DIGIT_W-1:0] DIG_SPACE   = 6'd0;
  localparam logic [DIGIT_W-1:0] DIG_ALPHA_0 = 6'd1;
  localparam logic [DIGIT_W-1:0] DIG_ALPHA_1 = 6'd26;
  localparam logic [DIGIT_W-1:0] DIG_NUM_0   = 6'd27;
  localparam logic [DIGIT_W-1:0] DIG_NUM_1   = 6'd36;
  localparam logic [DIGIT_W-1:0] DIG_DASH    = 6'd37;
  localparam logic [DIGIT_W-1:0] DIG_SLASH   = 6'd38;
  localparam logic [DIGIT_W-1:0] DIG_DOT     = 6'd39;

  localparam logic [CHAR_W-1:0] BCAST_TEXT [NUM_POS] = '{
    7'h42, 7'h52, 7'h4F, 7'h41, 7'h44, 7'h43, 7'h41, 7'h53, 7'h54
  };

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              bcast;
    logic [WORD_W-1:0] value;
    logic [BITS_W-1:0] bits;
  } stage_t;

  typedef struct packed {
    logic [WORD_W-1:0]               code_word;
    logic [NUM_POS-1:0][CHAR_W-1:0]  chars;
    logic                            bcast;
  } result_t;

  function automatic logic [DIGIT_W-1:0] char_to_digit(input logic [IN_CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIG_SPACE;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = DIG_ALPHA_0 + 6'(c - 8'h41);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = DIG_NUM_0 + 6'(c - 8'h30);
    end else if (c == 8'h2D) begin
      d = DIG_DASH;
    end else if (c == 8'h2F) begin
      d = DIG_SLASH;
    end else if (c == 8'h2E) begin
      d = DIG_DOT;
    end
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = 7'h20;
    if (d >= DIG_ALPHA_0 && d <= DIG_ALPHA_1) begin
      c = 7'(d - DIG_ALPHA_0) + 7'h41;
    end else if (d >= DIG_NUM_0 && d <= DIG_NUM_1) begin
      c = 7'(d - DIG_NUM_0) + 7'h30;
    end else if (d == DIG_DASH) begin
      c = 7'h2D;
    end else if (d == DIG_SLASH) begin
      c = 7'h2F;
    end else if (d == DIG_DOT) begin
      c = 7'h2E;
    end
    return c;
  endfunction

  // Weight of cell j: 40 to the power of its digit position times 2 to the power of its bit.
  function automatic logic [WORD_W-1:0] cell_weight(input int unsigned j);
    logic [WORD_W-1:0] w;
    int unsigned       pos;
    w   = WORD_W'(1) << (DIGIT_W - 1 - (j % DIGIT_W));
    pos = NUM_POS - 1 - (j / DIGIT_W);
    for (int unsigned i = 0; i < pos; i++) begin
      w = WORD_W'(w * WORD_W'(RADIX));
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/callsign_base40_codec_core.sv -----
// ---------------------------------------------------------------------------
// Callsign base-40 codec core
// Encodes a nine-character callsign into a 48-bit base-40 address word, or
// decodes such a word back into characters.
// ---------------------------------------------------------------------------
// The block takes one item per cycle while req_stall is low. An item passes
// one entry stage, then a chain of 54 cells, one for each
// bit of the nine 6-bit digits, each doing a single 48-bit add or
// compare-and-subtract against its constant weight, then the output register.
// A skid entry behind the output register lets the block take new items while
// a result waits. Positions at or above CALL_CHARS are ignored when encoding
// and read as zero when decoding.
`timescale 1ns / 1ps
`default_nettype none

module callsign_base40_codec_core
  import ccb40_pkg::*;
#(
  parameter int unsigned CALL_CHARS = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 cmd,
  input  logic [IN_CHAR_W-1:0] in_char_0,
  input  logic [IN_CHAR_W-1:0] in_char_1,
  input  logic [IN_CHAR_W-1:0] in_char_2,
  input  logic [IN_CHAR_W-1:0] in_char_3,
  input  logic [IN_CHAR_W-1:0] in_char_4,
  input  logic [IN_CHAR_W-1:0] in_char_5,
  input  logic [IN_CHAR_W-1:0] in_char_6,
  input  logic [IN_CHAR_W-1:0] in_char_7,
  input  logic [IN_CHAR_W-1:0] in_char_8,
  input  logic [WORD_W-1:0]    code_word,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [WORD_W-1:0]    code_word_out,
  output logic [CHAR_W-1:0]    out_char_0,
  output logic [CHAR_W-1:0]    out_char_1,
  output logic [CHAR_W-1:0]    out_char_2,
  output logic [CHAR_W-1:0]    out_char_3,
  output logic [CHAR_W-1:0]    out_char_4,
  output logic [CHAR_W-1:0]    out_char_5,
  output logic [CHAR_W-1:0]    out_char_6,
  output logic [CHAR_W-1:0]    out_char_7,
  output logic [CHAR_W-1:0]    out_char_8,
  output logic                 is_broadcast
);

  logic [IN_CHAR_W-1:0] in_chars [NUM_POS];
  logic [BITS_W-1:0]    in_digits;
  stage_t               entry_next;
  logic                 en;

  logic   chain_valid [NUM_CELLS+1];
  stage_t chain_stage [NUM_CELLS+1];

  stage_t             last_stage;
  logic [DIGIT_W-1:0] digit;
  result_t            result_next;
  result_t            result;

  assign in_chars[0] = in_char_0;
  assign in_chars[1] = in_char_1;
  assign in_chars[2] = in_char_2;
  assign in_chars[3] = in_char_3;
  assign in_chars[4] = in_char_4;
  assign in_chars[5] = in_char_5;
  assign in_chars[6] = in_char_6;
  assign in_chars[7] = in_char_7;
  assign in_chars[8] = in_char_8;

  for (genvar k = 0; k < NUM_POS; k++) begin : g_in_digit
    if (k < CALL_CHARS) begin : g_used
      assign in_digits[k*DIGIT_W +: DIGIT_W] = char_to_digit(in_chars[k]);
    end else begin : g_unused
      assign in_digits[k*DIGIT_W +: DIGIT_W] = '0;
    end
  end

  assign req_stall = !en;

  always_comb begin
    entry_next.cmd   = cmd_t'(cmd);
    entry_next.bcast = cmd && (code_word == ALL_ONES);
    entry_next.value = cmd ? code_word : '0;
    entry_next.bits  = cmd ? '0 : in_digits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      chain_valid[0] <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain_stage[0] <= entry_next;
    end
  end

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    ccb40_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .weight     (cell_weight(j)),
      .prev_valid (chain_valid[j]),
      .prev_stage (chain_stage[j]),
      .valid      (chain_valid[j+1]),
      .stage      (chain_stage[j+1])
    );
  end

  assign last_stage = chain_stage[NUM_CELLS];

  // A word above the nine-digit range leaves up to 42 in the top digit, so
  // each digit is reduced modulo 40 before it is mapped to a character.
  always_comb begin
    result_next.code_word = (last_stage.cmd == CMD_DECODE) ? '0 : last_stage.value;
    result_next.bcast     = last_stage.bcast;
    for (int k = 0; k < NUM_POS; k++) begin
      digit = last_stage.bits[k*DIGIT_W +: DIGIT_W];
      if (digit >= DIGIT_W'(RADIX)) begin
        digit = digit - DIGIT_W'(RADIX);
      end
      if (last_stage.cmd != CMD_DECODE || k >= CALL_CHARS) begin
        result_next.chars[k] = '0;
      end else if (last_stage.bcast) begin
        result_next.chars[k] = BCAST_TEXT[k];
      end else begin
        result_next.chars[k] = digit_to_char(digit);
      end
    end
  end

  ccb40_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (chain_valid[NUM_CELLS]),
    .push_data  (result_next),
    .room       (en),
    .stall      (rsp_stall),
    .valid      (rsp_valid),
    .data       (result)
  );

  assign code_word_out = result.code_word;
  assign out_char_0    = result.chars[0];
  assign out_char_1    = result.chars[1];
  assign out_char_2    = result.chars[2];
  assign out_char_3    = result.chars[3];
  assign out_char_4    = result.chars[4];
  assign out_char_5    = result.chars[5];
  assign out_char_6    = result.chars[6];
  assign out_char_7    = result.chars[7];
  assign out_char_8    = result.chars[8];
  assign is_broadcast  = result.bcast;

endmodule

`default_nettype wire

// ----- rtl/ccb40_cell.sv -----
// ---------------------------------------------------------------------------
// Callsign base-40 codec cell
// One digit bit of the chain: adds its weight when encoding and the bit is set, or compares and
// subtracts its weight when decoding, and shifts the digit bit vector by one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccb40_cell
  import ccb40_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [WORD_W-1:0] weight,
  input  logic              prev_valid,
  input  stage_t            prev_stage,
  output logic              valid,
  output stage_t            stage
);

  logic              take;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] diff;
  stage_t            stage_next;

  always_comb begin
    sum  = prev_stage.value + weight;
    diff = prev_stage.value - weight;
    if (prev_stage.cmd == CMD_DECODE) begin
      take = (prev_stage.value >= weight);
    end else begin
      take = prev_stage.bits[BITS_W-1];
    end
    stage_next      = prev_stage;
    stage_next.bits = {prev_stage.bits[BITS_W-2:0], take};
    if (take) begin
      stage_next.value = (prev_stage.cmd == CMD_DECODE) ? diff : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage <= stage_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ccb40_out_buf.sv -----
// ---------------------------------------------------------------------------
// Callsign base-40 codec output buffer
// Output register with one skid entry, so the chain keeps moving while a
// finished result waits for its transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ccb40_out_buf
  import ccb40_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  input  result_t push_data,
  output logic    room,
  input  logic    stall,
  output logic    valid,
  output result_t data
);

  logic    skid_valid;
  result_t skid_data;
  logic    push;
  logic    pop;

  assign room = !skid_valid || !stall;
  assign push = push_valid && room;
  assign pop  = valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        valid      <= 1'b1;
        skid_valid <= push;
      end else begin
        valid <= push;
      end
    end else if (!valid) begin
      valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        data <= skid_data;
        if (push) begin
          skid_data <= push_data;
        end
      end else if (push) begin
        data <= push_data;
      end
    end else if (!valid) begin
      data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire
